// File: rtl/core/bea_pkg.sv
// Shared types and constants for the bitmap entry allocator.
package bea_pkg;

    localparam int NUM_W = 14;
    localparam logic [NUM_W-1:0] ENTRIES_RESET = 14'd8192;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_ADR  = 7'b0010000,
        S_FCHK = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

endpackage

// File: rtl/core/bea_map_ram.sv
// Usage map storage: one write port, one read port with registered data.
module bea_map_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bitmap_entry_allocator.sv
// First-fit bitmap allocator: top level with command sequencer and result register.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+--------------------------------------------
//  in       | i_in_valid / o_in_stall         | i_cmd, i_entry_number
//  out      | o_out_valid / i_out_stall       | o_status, o_allocated_number, o_free_count
//  cfg      | i_cfg_we                        | i_cfg_wdata (entries_in_use)
//
// An allocate scans N map words (1 .. MAP_BITS/WORD_BITS), one word per cycle through the
// map memory read port; with a zero limit it reads no word. A free steps through S_DIV,
// S_ADR and S_FCHK, or goes straight to S_FIN when the number is zero or above the limit.
// After reset a clearing pass writes every map word with o_in_stall high. One item is in
// work at a time; a finished result waits in the output register, and a new item is taken
// while it is stalled.
module bitmap_entry_allocator
    import bea_pkg::*;
#(
    parameter int MAP_BITS  = 8192,
    parameter int WORD_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_cmd,
    input  logic [NUM_W-1:0] i_entry_number,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_status,
    output logic [NUM_W-1:0] o_allocated_number,
    output logic [NUM_W-1:0] o_free_count,
    input  logic             i_cfg_we,
    input  logic [NUM_W-1:0] i_cfg_wdata
);

    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int DIV_SH    = 28;
    localparam int RECIP_W   = 26;
    localparam int PROD_W    = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((2 ** DIV_SH) + WORD_BITS - 1) / WORD_BITS);
    localparam logic [16:0] MAP_BITS_W = 17'(MAP_BITS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_WORDS - 1);
    localparam logic [NUM_W-1:0] WORD_BITS_N = NUM_W'(WORD_BITS);

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [NUM_W-1:0]     r_base, n_base;
    logic [NUM_W-1:0]     r_idx, n_idx;
    logic [NUM_W-1:0]     r_lim, n_lim;
    logic [NUM_W-1:0]     r_used, n_used;
    t_status              r_status, n_status;
    logic [NUM_W-1:0]     r_number, n_number;
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [NUM_W-1:0]     r_out_number, n_out_number;
    logic [NUM_W-1:0]     r_out_free, n_out_free;
    logic [NUM_W-1:0]     r_entries_in_use;

    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;

    logic [NUM_W-1:0]     lim_now;
    logic                 accept;
    logic [NUM_W-1:0]     remaining;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] lowest;
    logic [BIT_W-1:0]     pos;
    logic [PROD_W-1:0]    prod;
    logic [BIT_W-1:0]     fpos;
    logic [NUM_W-1:0]     fdiff;

    bea_map_ram #(
        .DEPTH  (MAP_WORDS),
        .WIDTH  (WORD_BITS),
        .ADDR_W (ADDR_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata (mem_wdata),
        .i_raddr (n_addr),
        .o_rdata (mem_rdata)
    );

    assign lim_now = ({3'b000, r_entries_in_use} > MAP_BITS_W) ? NUM_W'(MAP_BITS)
                                                              : r_entries_in_use;
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // first clear bit below the limit in the current word
    always_comb begin
        remaining = r_lim - r_base;
        for (int b = 0; b < WORD_BITS; b++) begin
            free_bits[b] = !mem_rdata[b] && (NUM_W'(b) < remaining);
        end
        lowest = free_bits & (~free_bits + WORD_BITS'(1));
        pos = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (lowest[b]) begin
                pos = pos | BIT_W'(b);
            end
        end
    end

    // word index of a freed entry: reciprocal multiply, exact for 14-bit indexes
    assign prod  = PROD_W'(r_idx) * PROD_W'(RECIP);
    assign fdiff = r_idx - r_base;
    assign fpos  = fdiff[BIT_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_base       = r_base;
        n_idx        = r_idx;
        n_lim        = r_lim;
        n_used       = r_used;
        n_status     = r_status;
        n_number     = r_number;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_number = r_out_number;
        n_out_free   = r_out_free;
        mem_we       = 1'b0;
        mem_wdata    = '0;

        unique case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_lim    = lim_now;
                    n_idx    = i_entry_number - NUM_W'(1);
                    n_base   = '0;
                    n_addr   = '0;
                    n_number = '0;
                    n_status = ST_OK;
                    if (i_cmd == CMD_ALLOC) begin
                        if (lim_now == '0) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (i_entry_number == '0 || i_entry_number > lim_now) begin
                            n_status = ST_BAD;
                            n_state  = S_FIN;
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (free_bits != '0) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata | lowest;
                    n_used    = r_used + NUM_W'(1);
                    n_number  = r_base + NUM_W'(pos) + NUM_W'(1);
                    n_state   = S_FIN;
                end else if (remaining <= WORD_BITS_N) begin
                    n_status = ST_FULL;
                    n_state  = S_FIN;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                    n_base = r_base + WORD_BITS_N;
                end
            end
            S_DIV: begin
                n_addr  = ADDR_W'(prod >> DIV_SH);
                n_state = S_ADR;
            end
            S_ADR: begin
                n_base  = NUM_W'(r_addr) * WORD_BITS_N;
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (mem_rdata[fpos]) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata & ~(WORD_BITS'(1) << fpos);
                    n_used    = r_used - NUM_W'(1);
                end else begin
                    n_status = ST_BAD;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_number = r_number;
                    n_out_free   = (r_lim > r_used) ? (r_lim - r_used) : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_CLR;
            r_addr           <= '0;
            r_used           <= '0;
            r_out_valid      <= 1'b0;
            r_entries_in_use <= ENTRIES_RESET;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_entries_in_use <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base       <= n_base;
        r_idx        <= n_idx;
        r_lim        <= n_lim;
        r_status     <= n_status;
        r_number     <= n_number;
        r_out_status <= n_out_status;
        r_out_number <= n_out_number;
        r_out_free   <= n_out_free;
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_allocated_number = r_out_number;
    assign o_free_count       = r_out_free;

endmodule

// File: tb/bea_checker.sv
// Checker for the bitmap entry allocator: tracks the map, predicts each result, compares.
module bea_checker
    import bea_pkg::*;
#(
    parameter int MAP_BITS = 8192
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic             i_cmd,
    input  logic [NUM_W-1:0] i_entry_number,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [1:0]       i_status,
    input  logic [NUM_W-1:0] i_allocated_number,
    input  logic [NUM_W-1:0] i_free_count,
    input  logic             i_cfg_we,
    input  logic [NUM_W-1:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status          status;
        logic [NUM_W-1:0] number;
        logic [NUM_W-1:0] free_left;
    } t_alloc_result;

    bit               entry_taken [MAP_BITS];
    logic [NUM_W-1:0] taken_count;
    logic [NUM_W-1:0] entries_limit;
    t_alloc_result    expected_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_alloc_result serve_command(input logic cmd,
                                                    input logic [NUM_W-1:0] num);
        t_alloc_result r;
        int            lim;
        bit            found;
        lim       = (entries_limit > MAP_BITS) ? MAP_BITS : int'(entries_limit);
        found     = 1'b0;
        r.status  = ST_OK;
        r.number  = '0;
        if (cmd == CMD_ALLOC) begin
            r.status = ST_FULL;
            for (int i = 0; i < lim && !found; i++) begin
                if (!entry_taken[i]) begin
                    entry_taken[i] = 1'b1;
                    taken_count    = taken_count + 1'b1;
                    r.number       = NUM_W'(i + 1);
                    r.status       = ST_OK;
                    found          = 1'b1;
                end
            end
        end else if (num == '0 || int'(num) > lim || !entry_taken[num - 1'b1]) begin
            r.status = ST_BAD;
        end else begin
            entry_taken[num - 1'b1] = 1'b0;
            taken_count             = taken_count - 1'b1;
        end
        r.free_left = (lim > int'(taken_count)) ? NUM_W'(lim - int'(taken_count)) : '0;
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input int want, input int got);
        o_fail_count++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_alloc_result want;
        if (!i_rst_n) begin
            foreach (entry_taken[i]) entry_taken[i] = 1'b0;
            taken_count   = '0;
            entries_limit = ENTRIES_RESET;
            expected_q.delete();
        end else begin
            if (i_cfg_we)
                entries_limit = i_cfg_wdata;
            // Results first: a result leaving now never belongs to an item entering now.
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    $error("result with no item waiting: status %0d number %0d",
                           i_status, i_allocated_number);
                end else begin
                    want = expected_q.pop_front();
                    if (i_status !== want.status)
                        flag_mismatch("status", want.status, i_status);
                    if (i_allocated_number !== want.number)
                        flag_mismatch("allocated_number", want.number, i_allocated_number);
                    if (i_free_count !== want.free_left)
                        flag_mismatch("free_count", want.free_left, i_free_count);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(serve_command(i_cmd, i_entry_number));
        end
        o_pending = expected_q.size();
    end

endmodule

// File: tb/tb.sv
// Testbench top for the bitmap entry allocator: clock, reset, stimulus and verdict.
module tb;
    import bea_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_BITS        = 8192;
    localparam int NUM_PHASES      = 10;
    localparam int PHASE_ITEMS     = 43;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             cmd = CMD_ALLOC;
    logic [NUM_W-1:0] entry_number = '0;
    logic             out_stall = 1'b0;
    logic             cfg_we = 1'b0;
    logic [NUM_W-1:0] cfg_wdata = '0;

    logic             in_stall;
    logic             out_valid;
    logic [1:0]       status;
    logic [NUM_W-1:0] allocated_number;
    logic [NUM_W-1:0] free_count;

    int               fail_count;
    int               pending;
    int               idle_cycles = 0;

    bit               in_quiet = 1'b0;
    bit               out_quiet = 1'b0;
    bit               hold_off_req = 1'b0;
    int unsigned      allocs_sent = 0;
    int unsigned      limit_now = MAP_BITS;

    bitmap_entry_allocator #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (32)
    ) i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_cmd              (cmd),
        .i_entry_number     (entry_number),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_status           (status),
        .o_allocated_number (allocated_number),
        .o_free_count       (free_count),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata)
    );

    bea_checker #(
        .MAP_BITS (MAP_BITS)
    ) u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_cmd              (cmd),
        .i_entry_number     (entry_number),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_status           (status),
        .i_allocated_number (allocated_number),
        .i_free_count       (free_count),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Valid stays high after acceptance; the next item or idle() takes it down.
    task automatic send_item(input logic c, input logic [NUM_W-1:0] num);
        int unsigned gap;
        gap = in_quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        entry_number <= num;
        if (c == CMD_ALLOC)
            allocs_sent++;
        do @(posedge clk); while (in_stall);
    endtask

    // Drain every outstanding result before touching the limit register.
    task automatic idle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(input logic [NUM_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_now = (value > MAP_BITS) ? MAP_BITS : value;
    endtask

    task automatic random_item();
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(0, 99);
        span = ((allocs_sent < limit_now) ? allocs_sent : limit_now) + 2;
        if (pick < 55)
            send_item(CMD_ALLOC, NUM_W'($urandom));
        else if (pick < 90)
            send_item(CMD_FREE, NUM_W'($urandom_range(1, span)));
        else
            send_item(CMD_FREE, NUM_W'($urandom));
    endtask

    initial begin
        logic [NUM_W-1:0] phase_limit [NUM_PHASES];
        phase_limit = '{14'd40, 14'd1, 14'd16383, 14'd0, 14'd100, 14'd8192, 14'd33,
                        14'd9000, 14'd3, 14'd0};
        phase_limit[NUM_PHASES-1] = NUM_W'($urandom_range(1, MAP_BITS));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: bad frees, first fit, reuse of a freed entry
        send_item(CMD_FREE, 14'd0);
        send_item(CMD_FREE, 14'd1);
        repeat (3) send_item(CMD_ALLOC, 14'd0);
        send_item(CMD_FREE, 14'd2);
        send_item(CMD_ALLOC, 14'd0);
        send_item(CMD_FREE, 14'h3FFF);
        send_item(CMD_FREE, 14'd8192);
        send_item(CMD_ALLOC, 14'h3FFF);
        idle();
        // zero limit: every alloc fails, every free is out of range
        set_limit(14'd0);
        send_item(CMD_ALLOC, 14'd0);
        send_item(CMD_FREE, 14'd1);
        idle();
        // limit above map size saturates
        set_limit(14'h3FFF);
        send_item(CMD_ALLOC, 14'd0);
        idle();
        // lowered limit: entries above it stay taken, free count floors at zero
        set_limit(14'd2);
        send_item(CMD_ALLOC, 14'd0);
        send_item(CMD_FREE, 14'd3);
        send_item(CMD_FREE, 14'd1);
        send_item(CMD_ALLOC, 14'd0);
        idle();
        set_limit(14'd6);
        send_item(CMD_ALLOC, 14'd0);
        send_item(CMD_ALLOC, 14'd0);
        idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_limit(phase_limit[p]);
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            if (p == 2) begin
                // sink holds off while items keep coming, so the input backs up
                in_quiet     = 1'b1;
                hold_off_req = 1'b1;
            end
            repeat (PHASE_ITEMS) random_item();
            idle();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        int unsigned wait_cycles;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            wait_cycles = out_quiet ? 0 : $urandom_range(0, 15);
            if (wait_cycles != 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
